>>> rtl/ipv4_mutable_option_clearer_assert.svh
// Assertion macros for the IPv4 mutable option clearer.
// Included by the module that asserts; no other dependencies.
`ifndef IPV4_MUTABLE_OPTION_CLEARER_ASSERT_SVH
`define IPV4_MUTABLE_OPTION_CLEARER_ASSERT_SVH

// condition must hold at every edge outside reset
`define IMOC_ASSERT_ALWAYS(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IMOC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/imoc_pkg.sv
// Shared types, option codes and helpers for the IPv4 mutable option clearer.
// No dependencies.
`timescale 1ns / 1ps

package imoc_pkg;

  localparam logic [7:0] OPT_EOL       = 8'd0;
  localparam logic [7:0] OPT_NOP       = 8'd1;
  localparam logic [7:0] OPT_SEC       = 8'd130;
  localparam logic [7:0] OPT_LSRR      = 8'd131;
  localparam logic [7:0] OPT_ESEC      = 8'h85;
  localparam logic [7:0] OPT_CIPSO     = 8'h86;
  localparam logic [7:0] OPT_SSRR      = 8'd137;
  localparam logic [7:0] OPT_RTR_ALERT = 8'd148;
  localparam logic [7:0] OPT_SDB       = 8'h95;  // 0x80 | 21

  localparam logic [7:0] ROUTE_MIN_LEN = 8'd6;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LEN,
    PH_DATA,
    PH_PASS
  } phase_t;

  typedef struct packed {
    logic [5:0]  bytes_left;
    phase_t      phase;
    logic [7:0]  cur_type;
    logic [7:0]  cur_len;
    logic [7:0]  pos;
    logic [31:0] addr;
    logic        addr_found;
    logic        error_seen;
  } parse_state_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic        last_out;
    logic        status;
    logic [31:0] final_dest;
    logic        dest_found;
  } result_t;

  function automatic logic is_route(input logic [7:0] t);
    return t inside {OPT_LSRR, OPT_SSRR};
  endfunction

  function automatic logic is_kept(input logic [7:0] t);
    return t inside {OPT_SEC, OPT_ESEC, OPT_CIPSO, OPT_RTR_ALERT, OPT_SDB};
  endfunction

endpackage

>>> rtl/ipv4_mutable_option_clearer.sv
// Channel   | dir | payload
// s_axis    | in  | tdata: option_byte, area_length; tuser: start_of_area
// m_axis    | out | tdata: byte_out, status, final_dest, dest_found; tlast: last_out
//
// One item per cycle sustained while m_axis_tready holds; each item passes the
// input register, then the result register behind the parser step.
// The parser state update is a single step per byte, so throughput is set by
// that step alone. rst is synchronous and clears both stage valids and the
// parser state. A stalled output holds its result and back-pressure reaches the
// input stage combinationally, in the same cycle. Depends on imoc_pkg, imoc_parse
// and the assertion macro header.
`timescale 1ns / 1ps
`include "ipv4_mutable_option_clearer_assert.svh"

module ipv4_mutable_option_clearer import imoc_pkg::*; #(
  parameter int unsigned MAX_OPTION_BYTES = 40
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] option_byte, [13:8] area_length, rest 0
  input  logic        s_axis_tuser,   // [0] start_of_area
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] byte_out, [8] status, [40:9] final_dest,
                                      // [41] dest_found, rest 0
  output logic        m_axis_tlast
);

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_start;
  logic [5:0]   in_len;

  logic         out_valid;
  result_t      out_res;

  parse_state_t st;
  parse_state_t st_next;
  result_t      res;

  logic         advance;
  logic         fire;

  assign advance       = !out_valid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  imoc_parse #(
    .MAX_OPTION_BYTES(MAX_OPTION_BYTES)
  ) u_parse (
    .st            (st),
    .option_byte   (in_byte),
    .start_of_area (in_start),
    .area_length   (in_len),
    .st_next       (st_next),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
        if (s_axis_tvalid) begin
          in_byte  <= s_axis_tdata[7:0];
          in_len   <= s_axis_tdata[13:8];
          in_start <= s_axis_tuser;
        end
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        out_res <= res;
        st      <= st_next;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_res.last_out;
  assign m_axis_tdata  = {6'd0, out_res.dest_found, out_res.final_dest,
                          out_res.status, out_res.byte_out};

  `IMOC_ASSERT_ALWAYS(a_idle_expects_type, clk, rst,
    st.bytes_left != 6'd0 || st.phase == PH_TYPE, "closed area not in expect-type")
  `IMOC_ASSERT_ALWAYS(a_left_bounded, clk, rst,
    {26'd0, st.bytes_left} <= 32'(MAX_OPTION_BYTES), "bytes left above area limit")
  `IMOC_ASSERT_NEXT(a_last_closes_area, clk, rst,
    fire && res.last_out, st.bytes_left == 6'd0 && out_valid && m_axis_tlast,
    "last byte did not close the area")

endmodule

>>> rtl/imoc_parse.sv
// Option parser step: next parser state and the result for one option byte.
// Depends on imoc_pkg.
`timescale 1ns / 1ps

module imoc_parse import imoc_pkg::*; #(
  parameter int unsigned MAX_OPTION_BYTES = 40
) (
  input  parse_state_t st,
  input  logic [7:0]   option_byte,
  input  logic         start_of_area,
  input  logic [5:0]   area_length,
  output parse_state_t st_next,
  output result_t      res
);

  localparam logic [5:0] MaxLen = 6'(MAX_OPTION_BYTES);

  logic [5:0] len;
  logic [5:0] left;
  logic [7:0] pos_inc;

  always_comb begin
    st_next      = st;
    res.byte_out = option_byte;
    res.last_out = 1'b0;
    len          = area_length;
    left         = 6'd0;
    pos_inc      = 8'd0;

    if (start_of_area) begin
      if (len == 6'd0) len = 6'd1;
      if (len > MaxLen) len = MaxLen;
      st_next            = '0;
      st_next.bytes_left = len;
      st_next.phase      = PH_TYPE;
    end

    if (st_next.bytes_left != 6'd0) begin
      left = st_next.bytes_left;
      case (st_next.phase)
        PH_TYPE: begin
          if (option_byte == OPT_EOL) begin
            st_next.phase = PH_PASS;
          end else if (option_byte == OPT_NOP) begin
            st_next.phase = PH_TYPE;
          end else if (left < 6'd2) begin
            // type with no room for its length byte
            st_next.error_seen = 1'b1;
            st_next.phase      = PH_PASS;
          end else begin
            st_next.cur_type = option_byte;
            st_next.pos      = 8'd1;
            st_next.phase    = PH_LEN;
          end
        end
        PH_LEN: begin
          // option started one byte earlier, so left + 1 bytes were available
          if (option_byte < 8'd2 || {1'b0, option_byte} > ({3'b0, left} + 9'd1) ||
              (is_route(st_next.cur_type) && option_byte < ROUTE_MIN_LEN)) begin
            st_next.error_seen = 1'b1;
            st_next.phase      = PH_PASS;
          end else begin
            st_next.cur_len = option_byte;
            st_next.pos     = 8'd2;
            st_next.phase   = (option_byte == 8'd2) ? PH_TYPE : PH_DATA;
          end
        end
        PH_DATA: begin
          if (is_route(st_next.cur_type) &&
              ({1'b0, st_next.pos} + 9'd4) >= {1'b0, st_next.cur_len}) begin
            st_next.addr = {st_next.addr[23:0], option_byte};
            if (({1'b0, st_next.pos} + 9'd1) == {1'b0, st_next.cur_len})
              st_next.addr_found = 1'b1;
          end
          if (!is_kept(st_next.cur_type)) res.byte_out = 8'd0;
          pos_inc     = st_next.pos + 8'd1;
          st_next.pos = pos_inc;
          if (pos_inc >= st_next.cur_len) st_next.phase = PH_TYPE;
        end
        default: begin
          st_next.phase = PH_PASS;
        end
      endcase
      st_next.bytes_left = left - 6'd1;
      if (st_next.bytes_left == 6'd0) begin
        res.last_out  = 1'b1;
        st_next.phase = PH_TYPE;
      end
    end

    res.status     = st_next.error_seen;
    res.final_dest = st_next.addr;
    res.dest_found = st_next.addr_found;
  end

endmodule

>>> tb/tb.sv
// Self-checking bench for ipv4_mutable_option_clearer: random option areas in, bytes checked out.
// Predicts each cleared byte, status and final destination in-bench; needs imoc_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import imoc_pkg::*;

  localparam int AREA_MAX = 40;

  typedef struct {
    logic [7:0] opt_byte;
    logic       sof;
    logic [5:0] alen;
  } opt_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [7:0] option_byte, [13:8] area_length
  logic        s_axis_tuser = 1'b0;  // [0] start_of_area
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;  // [7:0] byte_out, [8] status, [40:9] final_dest, [41] dest_found
  logic        m_axis_tlast;

  ipv4_mutable_option_clearer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  opt_item_t pending_q[$];
  result_t   expected_opt_bytes[$];
  int        bytes_accepted = 0;
  int        results_seen = 0;
  int        mismatches = 0;
  int        send_gap = 0;
  int        recv_stall = 0;
  int        holdoff_left = 0;
  bit        holdoff_done = 1'b0;
  bit        send_burst = 1'b0;
  bit        recv_burst = 1'b0;

  // parser copy
  logic [5:0]  left_cnt = '0;
  phase_t      ph = PH_TYPE;
  logic [7:0]  opt_type = '0;
  logic [7:0]  opt_len = '0;
  logic [7:0]  opt_pos = '0;
  logic [31:0] dest_acc = '0;
  logic        dest_ok = 1'b0;
  logic        malformed = 1'b0;

  function automatic bit is_source_route(input logic [7:0] t);
    return (t == OPT_LSRR) || (t == OPT_SSRR);
  endfunction

  function automatic bit data_is_kept(input logic [7:0] t);
    case (t)
      OPT_SEC, OPT_ESEC, OPT_CIPSO, OPT_RTR_ALERT, OPT_SDB: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic clear_option_byte(input logic [7:0] b, input logic sof, input logic [5:0] alen,
                                   output result_t r);
    r.byte_out = b;
    r.last_out = 1'b0;
    if (sof) begin
      left_cnt  = (alen == 0) ? 6'd1 : ((alen > AREA_MAX) ? 6'(AREA_MAX) : alen);
      ph        = PH_TYPE;
      opt_type  = '0;
      opt_len   = '0;
      opt_pos   = '0;
      dest_acc  = '0;
      dest_ok   = 1'b0;
      malformed = 1'b0;
    end
    if (left_cnt != 0) begin
      case (ph)
        PH_TYPE: begin
          if (b == OPT_EOL) ph = PH_PASS;
          else if (b == OPT_NOP) ph = PH_TYPE;
          else if (left_cnt < 2) begin
            // no room left for a length byte
            malformed = 1'b1;
            ph = PH_PASS;
          end else begin
            opt_type = b;
            opt_pos  = 8'd1;
            ph       = PH_LEN;
          end
        end
        PH_LEN: begin
          // the option started one byte earlier
          if (b < 2 || int'(b) > int'(left_cnt) + 1 ||
              (is_source_route(opt_type) && b < ROUTE_MIN_LEN)) begin
            malformed = 1'b1;
            ph = PH_PASS;
          end else begin
            opt_len = b;
            opt_pos = 8'd2;
            ph      = (b == 2) ? PH_TYPE : PH_DATA;
          end
        end
        PH_DATA: begin
          if (is_source_route(opt_type) && int'(opt_pos) + 4 >= int'(opt_len)) begin
            dest_acc = {dest_acc[23:0], b};
            if (int'(opt_pos) + 1 == int'(opt_len)) dest_ok = 1'b1;
          end
          if (!data_is_kept(opt_type)) r.byte_out = '0;
          opt_pos = opt_pos + 8'd1;
          if (opt_pos >= opt_len) ph = PH_TYPE;
        end
        default: ;
      endcase
      left_cnt = left_cnt - 6'd1;
      if (left_cnt == 0) begin
        r.last_out = 1'b1;
        ph = PH_TYPE;
      end
    end
    r.status     = malformed;
    r.final_dest = dest_acc;
    r.dest_found = dest_ok;
  endtask

  function automatic int idle_cycles(input bit burst);
    return burst ? 0 : int'($urandom_range(0, 17));
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic sof, input logic [5:0] alen);
    opt_item_t it;
    it.opt_byte = b;
    it.sof      = sof;
    it.alen     = alen;
    pending_q.push_back(it);
  endtask

  // first byte opens the area; area_length on the rest is don't-care and random
  task automatic queue_run(input logic [5:0] alen, input logic [7:0] run[$]);
    foreach (run[i]) queue_byte(run[i], i == 0, (i == 0) ? alen : 6'($urandom_range(0, 63)));
  endtask

  task automatic queue_area(input logic [5:0] alen, input bit noise, input bit cut);
    logic [7:0] run[$];
    int         room, left, kind, olen, stop;
    logic [7:0] t;
    room = (alen == 0) ? 1 : ((alen > AREA_MAX) ? AREA_MAX : int'(alen));
    while (run.size() < room) begin
      left = room - run.size();
      kind = noise ? -1 : int'($urandom_range(0, 19));
      t    = 8'($urandom_range(2, 255));
      if (kind < 0) run.push_back(8'($urandom_range(0, 255)));
      else if (kind < 3) run.push_back(OPT_NOP);
      else if (kind == 3) begin
        run.push_back(OPT_EOL);
        while (run.size() < room) run.push_back(8'($urandom_range(0, 255)));
      end else if (kind <= 5) begin
        // broken length byte, or a route too short to hold an address
        if (kind == 5) t = $urandom_range(0, 1) ? OPT_LSRR : OPT_SSRR;
        run.push_back(t);
        if (left > 1) begin
          if (kind == 5) run.push_back(8'($urandom_range(2, 5)));
          else if ($urandom_range(0, 1)) run.push_back(8'($urandom_range(0, 1)));
          else run.push_back(8'($urandom_range(left + 1, 255)));
        end
        while (run.size() < room) run.push_back(8'($urandom_range(0, 255)));
      end else if (kind == 6) begin
        // type lands on the final byte
        while (run.size() < room - 1) run.push_back(OPT_NOP);
        run.push_back(t);
      end else begin
        if (kind < 11) t = $urandom_range(0, 1) ? OPT_LSRR : OPT_SSRR;
        else if (kind < 14) begin
          case ($urandom_range(0, 4))
            0: t = OPT_SEC;
            1: t = OPT_ESEC;
            2: t = OPT_CIPSO;
            3: t = OPT_RTR_ALERT;
            default: t = OPT_SDB;
          endcase
        end
        olen = is_source_route(t) ? int'(ROUTE_MIN_LEN) : 2;
        if (left < olen) run.push_back(OPT_NOP);
        else begin
          olen = $urandom_range(olen, left);
          run.push_back(t);
          run.push_back(8'(olen));
          repeat (olen - 2) run.push_back(8'($urandom_range(0, 255)));
        end
      end
    end
    if (cut && room > 1) begin
      // next area restarts the parser mid-way
      stop = $urandom_range(1, room - 1);
      while (run.size() > stop) void'(run.pop_back());
    end
    queue_run(alen, run);
  endtask

  // sender
  always @(posedge clk) begin
    opt_item_t it;
    result_t   want;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        clear_option_byte(s_axis_tdata[7:0], s_axis_tuser, s_axis_tdata[13:8], want);
        expected_opt_bytes.push_back(want);
        bytes_accepted <= bytes_accepted + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          it = pending_q.pop_front();
          s_axis_tdata  <= {2'b00, it.alen, it.opt_byte};
          s_axis_tuser  <= it.sof;
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
          send_gap <= idle_cycles(send_burst);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once, so the pipe fills and backs up
  always @(posedge clk) begin
    if (rst) begin
      holdoff_left <= 0;
      holdoff_done <= 1'b0;
    end else if (!holdoff_done && bytes_accepted >= 400) begin
      holdoff_left <= 300;
      holdoff_done <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  task automatic note_mismatch(input string field, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s on result %0d: expected %h, got %h", field, results_seen, want, got);
  endtask

  // receiver and checker
  always @(posedge clk) begin
    result_t got, want;
    int      stall_v;
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_stall    <= 0;
    end else begin
      stall_v = recv_stall;
      if (m_axis_tvalid && m_axis_tready) begin
        got.byte_out   = m_axis_tdata[7:0];
        got.status     = m_axis_tdata[8];
        got.final_dest = m_axis_tdata[40:9];
        got.dest_found = m_axis_tdata[41];
        got.last_out   = m_axis_tlast;
        if (expected_opt_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with nothing expected: %h", results_seen, m_axis_tdata);
        end else begin
          want = expected_opt_bytes.pop_front();
          if (got.byte_out !== want.byte_out) note_mismatch("byte_out", want.byte_out, got.byte_out);
          if (got.last_out !== want.last_out) note_mismatch("last_out", want.last_out, got.last_out);
          if (got.status !== want.status) note_mismatch("status", want.status, got.status);
          if (got.final_dest !== want.final_dest)
            note_mismatch("final_dest", want.final_dest, got.final_dest);
          if (got.dest_found !== want.dest_found)
            note_mismatch("dest_found", want.dest_found, got.dest_found);
        end
        results_seen++;
        if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
        stall_v = idle_cycles(recv_burst);
      end else if (stall_v != 0) begin
        stall_v--;
      end
      recv_stall    <= stall_v;
      m_axis_tready <= (stall_v == 0) && (holdoff_left == 0);
    end
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [7:0] run[$];
    int         sel;
    int         total;
    // route with address then end-of-list and a trailing byte
    run = {OPT_NOP, OPT_LSRR, 8'd7, 8'd4, 8'hC0, 8'hA8, 8'h01, 8'hFE, OPT_EOL, 8'hFF};
    queue_run(6'd10, run);
    // kept option, cleared option, then a type on the last byte
    run = {OPT_RTR_ALERT, 8'd4, 8'hFF, 8'hFF, 8'd7, 8'd3, 8'hFF, 8'h44};
    queue_run(6'd8, run);
    // zero length counts as one
    run = {OPT_NOP};
    queue_run(6'd0, run);
    // saturated length, short route, cut off by a new area
    run = {OPT_SSRR, 8'd5, 8'h12};
    queue_run(6'd63, run);
    // length beyond the area
    run = {8'h44, 8'd5, 8'h99};
    queue_run(6'd3, run);
    // bytes with no area open
    queue_byte(8'hA5, 1'b0, 6'h3F);
    queue_byte(8'h5A, 1'b0, 6'h00);

    while (pending_q.size() < 1530) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        case ($urandom_range(0, 2))
          0: queue_area(6'd0, 1'b0, 1'b0);
          1: queue_area(6'($urandom_range(41, 63)), 1'b0, $urandom_range(0, 3) == 0);
          default: queue_area(6'd40, 1'b0, 1'b0);
        endcase
      end else if (sel < 85) begin
        queue_area(6'($urandom_range(1, 40)), 1'b0, $urandom_range(0, 19) == 0);
      end else if (sel < 93) begin
        queue_area(6'($urandom_range(0, 63)), 1'b1, $urandom_range(0, 9) == 0);
      end else begin
        repeat ($urandom_range(1, 3))
          queue_byte(8'($urandom_range(0, 255)), 1'b0, 6'($urandom_range(0, 63)));
      end
    end
    // every item gives exactly one result
    total = pending_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (results_seen < total)
      @(posedge clk);
    // two-stage pipe: allow for anything straggling out
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
